### hdl/prlt_pkg.sv
// Package for the per-id rate limit table.
// Holds table sizing, outcome codes, controller state and the command/status structs.
// Used by prlt_ctrl, prlt_dp and per_id_rate_limit_table.
package prlt_pkg;

    // Table sizing
    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    // Field widths
    localparam int ID_W       = 16;
    localparam int PAN_W      = 8;
    localparam int TIME_W     = 32;
    localparam int INTERVAL_W = 16;
    localparam int OUTCOME_W  = 3;

    // Stream widths
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 4;

    // Blackout interval after reset, in ms
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd50;

    // Outcome codes
    typedef enum logic [OUTCOME_W-1:0] {
        OUTCOME_SUPPRESSED = 3'd0,
        OUTCOME_REFRESHED  = 3'd1,
        OUTCOME_REPLACED   = 3'd2,
        OUTCOME_APPENDED   = 3'd3,
        OUTCOME_DROPPED    = 3'd4
    } outcome_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic start;   // capture request, clear scan state
        logic scan;    // allow table reads
        logic commit;  // update table, load result register
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;  // no read left to issue, pipeline empty
        logic out_free;   // result register can take a beat
    } dp_stat_t;

endpackage

### hdl/prlt_ctrl.sv
// Controller state machine for the per-id rate limit table.
// Sequences capture, table scan and commit; drives the datapath by command struct.
// Depends on prlt_pkg.
module prlt_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  prlt_pkg::dp_stat_t  stat,
    output prlt_pkg::ctrl_cmd_t cmd
);
    import prlt_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (stat.scan_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        s_tready   = 1'b0;
        cmd.start  = 1'b0;
        cmd.scan   = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                cmd.start = s_tvalid;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
            end
            ST_FINISH: begin
                cmd.commit = stat.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

### hdl/prlt_dp.sv
// Datapath for the per-id rate limit table.
// Holds the entry memory, the three-stage scan pipeline, the decision and result register.
// Depends on prlt_pkg.
module prlt_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [prlt_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic                                 cfg_we,
    input  logic [prlt_pkg::INTERVAL_W-1:0]      cfg_wdata,
    input  prlt_pkg::ctrl_cmd_t                  cmd,
    output prlt_pkg::dp_stat_t                   stat,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [prlt_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic [prlt_pkg::M_TUSER_W-1:0]       m_tuser
);
    import prlt_pkg::*;

    localparam int ENTRY_W = TIME_W + ID_W;

    // Entry memory: {time, id}
    logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];

    // Configuration and table fill
    logic [INTERVAL_W-1:0] interval_reg;
    logic [CNT_W-1:0]      used_reg;

    // Captured request
    logic [ID_W-1:0]   id_reg;
    logic [PAN_W-1:0]  pan_reg;
    logic [TIME_W-1:0] now_reg;

    // Scan pipeline
    logic [CNT_W-1:0]   rd_idx_reg;
    logic               vld1_reg;
    logic [IDX_W-1:0]   idx1_reg;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               vld2_reg;
    logic [IDX_W-1:0]   idx2_reg;
    logic [TIME_W-1:0]  age2_reg;
    logic               match2_reg;

    // Scan results
    logic              hit_reg;
    logic              hit_ok_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic              have_oldest_reg;
    logic [IDX_W-1:0]  oldest_idx_reg;
    logic [TIME_W-1:0] oldest_age_reg;

    // Result register
    logic              m_valid_reg;
    logic              play_reg;
    logic [ID_W-1:0]   play_id_reg;
    logic [PAN_W-1:0]  play_pan_reg;
    outcome_t          outcome_reg;

    logic             issue;
    logic             replace_ok;
    logic             table_full;
    logic             dec_play;
    outcome_t         dec_outcome;
    logic             dec_write;
    logic [IDX_W-1:0] dec_addr;
    logic             dec_grow;

    assign issue = cmd.scan && !hit_reg && (rd_idx_reg < used_reg);

    assign stat.scan_done = !issue && !vld1_reg && !vld2_reg;
    assign stat.out_free  = !m_valid_reg || m_tready;

    // Interval register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= INTERVAL_RESET;
        end else if (cfg_we) begin
            interval_reg <= cfg_wdata;
        end
    end

    // Capture request beat
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            id_reg  <= s_tdata[ID_W-1:0];
            pan_reg <= s_tdata[ID_W+PAN_W-1:ID_W];
            now_reg <= s_tdata[ID_W+PAN_W+TIME_W-1:ID_W+PAN_W];
        end
    end

    // Memory: read for the scan, write on commit
    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_data_reg <= mem[rd_idx_reg[IDX_W-1:0]];
        end
        if (dec_write) begin
            mem[dec_addr] <= {now_reg, id_reg};
        end
    end

    // Scan control: read index and stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_idx_reg <= '0;
            vld1_reg   <= 1'b0;
            vld2_reg   <= 1'b0;
        end else if (cmd.start) begin
            rd_idx_reg <= '0;
            vld1_reg   <= 1'b0;
            vld2_reg   <= 1'b0;
        end else begin
            vld1_reg <= issue;
            vld2_reg <= vld1_reg;
            if (issue) begin
                rd_idx_reg <= rd_idx_reg + CNT_W'(1);
            end
        end
    end

    // Stage two: age and id match
    always_ff @(posedge aclk) begin
        if (issue) begin
            idx1_reg <= rd_idx_reg[IDX_W-1:0];
        end
        if (vld1_reg) begin
            idx2_reg   <= idx1_reg;
            age2_reg   <= now_reg - rd_data_reg[ENTRY_W-1:ID_W];
            match2_reg <= (rd_data_reg[ID_W-1:0] == id_reg);
        end
    end

    // Stage three: first match, else track first oldest entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg         <= 1'b0;
            have_oldest_reg <= 1'b0;
        end else if (cmd.start) begin
            hit_reg         <= 1'b0;
            have_oldest_reg <= 1'b0;
        end else if (vld2_reg && !hit_reg) begin
            if (match2_reg) begin
                hit_reg <= 1'b1;
            end else if (!have_oldest_reg || (age2_reg > oldest_age_reg)) begin
                have_oldest_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (vld2_reg && !hit_reg) begin
            if (match2_reg) begin
                hit_idx_reg <= idx2_reg;
                hit_ok_reg  <= !(age2_reg < {{(TIME_W-INTERVAL_W){1'b0}}, interval_reg});
            end else if (!have_oldest_reg || (age2_reg > oldest_age_reg)) begin
                oldest_idx_reg <= idx2_reg;
                oldest_age_reg <= age2_reg;
            end
        end
    end

    // Decide outcome and table update
    assign replace_ok = have_oldest_reg &&
                        (oldest_age_reg > {{(TIME_W-INTERVAL_W){1'b0}}, interval_reg});
    assign table_full = (used_reg >= CNT_W'(TABLE_ENTRIES));

    always_comb begin
        dec_play    = 1'b0;
        dec_outcome = OUTCOME_DROPPED;
        dec_write   = 1'b0;
        dec_addr    = used_reg[IDX_W-1:0];
        dec_grow    = 1'b0;
        if (hit_reg) begin
            dec_addr = hit_idx_reg;
            if (hit_ok_reg) begin
                dec_play    = 1'b1;
                dec_outcome = OUTCOME_REFRESHED;
                dec_write   = cmd.commit;
            end else begin
                dec_outcome = OUTCOME_SUPPRESSED;
            end
        end else if (replace_ok) begin
            dec_addr    = oldest_idx_reg;
            dec_play    = 1'b1;
            dec_outcome = OUTCOME_REPLACED;
            dec_write   = cmd.commit;
        end else if (!table_full) begin
            dec_play    = 1'b1;
            dec_outcome = OUTCOME_APPENDED;
            dec_write   = cmd.commit;
            dec_grow    = cmd.commit;
        end
    end

    // Fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else if (dec_grow) begin
            used_reg <= used_reg + CNT_W'(1);
        end
    end

    // Result register: load on commit, drop valid when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            play_reg     <= dec_play;
            play_id_reg  <= dec_play ? id_reg : '0;
            play_pan_reg <= dec_play ? pan_reg : '0;
            outcome_reg  <= dec_outcome;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {play_pan_reg, play_id_reg};
    assign m_tuser  = {outcome_reg, play_reg};

endmodule

### hdl/per_id_rate_limit_table.sv
// Channel   | Signals                     | Beat contents (lowest bit first)
// ----------+-----------------------------+----------------------------------------------
// request   | s_tvalid s_tready s_tdata   | sound_id[15:0] pan_value[23:16] now_ms[55:24]
// result    | m_tvalid m_tready m_tdata   | play_id[15:0] play_pan[23:16]
//           | m_tuser                     | play[0] outcome[3:1]
// config    | cfg_we cfg_wdata            | min_gap_ms[15:0]
//
// The scan reads the used table entries one per cycle through a three-stage pipeline
// and stops issuing reads once the first id match is registered in stage three. Reset
// (aresetn low, synchronous) empties the table and sets the interval to 50 ms. The next
// request is taken while the result beat still waits; a stalled result holds the block
// only at commit of the following request.
//
// Top level of the per-id rate limit table; instantiates prlt_ctrl and prlt_dp.
// Depends on prlt_pkg.
module per_id_rate_limit_table (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [prlt_pkg::S_TDATA_W-1:0]    s_tdata,   // sound_id, pan_value, now_ms
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [prlt_pkg::M_TDATA_W-1:0]    m_tdata,   // play_id, play_pan
    output logic [prlt_pkg::M_TUSER_W-1:0]    m_tuser,   // play, outcome
    input  logic                              cfg_we,
    input  logic [prlt_pkg::INTERVAL_W-1:0]   cfg_wdata  // min_gap_ms
);
    import prlt_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    prlt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    prlt_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
